>>> design/sspf_pkg.sv
// Package for the speed sample plausibility filter.
// Holds the shared types, codes and reset constants; depends on nothing.
package sspf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int ACC_W    = 25;

	// item codes
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;
	localparam logic KIND_ERR    = 1'b0;
	localparam logic KIND_AVG    = 1'b1;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_MAX_NORMAL  = 3'd0,
		CFG_RUN_LIMIT   = 3'd1,
		CFG_GAP         = 3'd2,
		CFG_WINDOW      = 3'd3,
		CFG_SCALE       = 3'd4
	} sspf_cfg_idx_t;

	// register reset values
	localparam logic [15:0] RST_MAX_NORMAL = 16'h7FFF;
	localparam logic [7:0]  RST_RUN_LIMIT  = 8'd3;
	localparam logic [15:0] RST_GAP        = 16'd100;
	localparam logic [7:0]  RST_WINDOW     = 8'd20;
	localparam logic [15:0] RST_SCALE      = 16'd256;

	typedef struct packed {
		logic [15:0] max_normal;
		logic [7:0]  invalid_run_limit;
		logic [15:0] jump_gap;
		logic [7:0]  window_ticks;
		logic [15:0] scale_q8;
	} sspf_cfg_t;

	// result leaving the tracker: error value or accumulator snapshot
	typedef struct packed {
		logic                kind;
		logic [SAMPLE_W-1:0] value;
		logic [ACC_W-1:0]    acc;
		logic                ok;
	} sspf_res_t;

	// finished message
	typedef struct packed {
		logic                kind;
		logic [SAMPLE_W-1:0] value;
		logic                ok;
	} sspf_msg_t;

endpackage

>>> design/sspf_scale.sv
// Sample gain: raw * Q8.8 gain, truncated toward zero, saturated to 16 bits.
// Purely combinational; uses sspf_pkg.
module sspf_scale (
	input  logic [sspf_pkg::SAMPLE_W-1:0] raw_sample,
	input  logic [15:0]                   scale_q8,
	output logic [sspf_pkg::SAMPLE_W-1:0] scaled
);
	import sspf_pkg::*;

	logic signed [16:0] gain;
	logic signed [33:0] prod;
	logic [33:0]        biased;
	logic signed [25:0] quo;

	always_comb begin
		gain   = $signed({1'b0, scale_q8});
		prod   = $signed(raw_sample) * gain;
		// bias negatives by 255 so the shift truncates toward zero
		biased = prod + {26'd0, {8{prod[33]}}};
		quo    = $signed(biased[33:8]);
		if (quo > 26'sd32767) begin
			scaled = 16'h7FFF;
		end else if (quo < -26'sd32768) begin
			scaled = 16'h8000;
		end else begin
			scaled = quo[15:0];
		end
	end

endmodule

>>> design/sspf_track.sv
// Run, hold and window tracker: all filter state and the per-item decision.
// Uses sspf_pkg; state moves only when upd is high.
module sspf_track (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd,
	input  logic                          func,
	input  logic [sspf_pkg::SAMPLE_W-1:0] scaled,
	input  sspf_pkg::sspf_cfg_t           cfg,
	output logic                          has_res,
	output sspf_pkg::sspf_res_t           res
);
	import sspf_pkg::*;

	logic [7:0]          tick_q;
	logic [7:0]          bad_q;
	logic [ACC_W-1:0]    acc_q;
	logic [SAMPLE_W-1:0] held_q;
	logic                held_valid_q;
	logic                ok_q;

	logic [7:0]          tick_inc;
	logic [7:0]          bad_inc;
	logic                is_sample;
	logic                over;
	logic                normal;
	logic                err;
	logic                report;
	logic signed [16:0]  diff;
	logic [16:0]         diff_mag;
	logic                take;
	logic [SAMPLE_W-1:0] add_val;
	logic [ACC_W:0]      sum;
	logic [ACC_W-1:0]    acc_sat;
	logic [ACC_W-1:0]    acc_mid;
	logic                ok_next;

	always_comb begin
		tick_inc  = tick_q + 8'd1;
		is_sample = (func == FUNC_SAMPLE);
		over      = is_sample && ($signed(scaled) > $signed(cfg.max_normal));
		normal    = is_sample && !over;
		bad_inc   = (bad_q == 8'hFF) ? bad_q : bad_q + 8'd1;
		err       = over && (bad_inc > cfg.invalid_run_limit);

		diff     = $signed({scaled[15], scaled}) - $signed({held_q[15], held_q});
		diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
		take     = !held_valid_q || (diff_mag < {1'b0, cfg.jump_gap});
		add_val  = take ? scaled : held_q;

		sum = {acc_q[ACC_W-1], acc_q} + {{(ACC_W+1-SAMPLE_W){add_val[15]}}, add_val};
		// clamp at the 25-bit signed limits
		if (sum[ACC_W] == sum[ACC_W-1]) begin
			acc_sat = sum[ACC_W-1:0];
		end else begin
			acc_sat = {sum[ACC_W], {(ACC_W-1){~sum[ACC_W]}}};
		end
		acc_mid = normal ? acc_sat : acc_q;

		// an error clears the window, so it wins over a report
		report  = !err && (tick_inc == cfg.window_ticks);
		ok_next = err ? 1'b0 : (normal ? 1'b1 : ok_q);

		has_res   = err || report;
		res.kind  = err ? KIND_ERR : KIND_AVG;
		res.value = scaled;
		res.acc   = acc_mid;
		res.ok    = ok_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= '0;
			bad_q        <= '0;
			acc_q        <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			ok_q         <= 1'b1;
		end else if (upd) begin
			tick_q <= has_res ? '0 : tick_inc;
			acc_q  <= has_res ? '0 : acc_mid;
			if (normal) begin
				bad_q <= '0;
			end else if (over) begin
				bad_q <= bad_inc;
			end
			if (normal && take) begin
				held_q       <= scaled;
				held_valid_q <= 1'b1;
			end
			ok_q <= ok_next;
		end
	end

endmodule

>>> design/sspf_div.sv
// Window average: accumulator / AVG_DIVISOR by reciprocal multiply, two stages.
// Stage 3 multiplies the magnitude, stage 4 shifts, restores sign, saturates.
module sspf_div #(
	parameter int AVG_DIVISOR = 20
) (
	input  logic                clk,
	input  logic                en,
	input  sspf_pkg::sspf_res_t res,
	output sspf_pkg::sspf_msg_t msg
);
	import sspf_pkg::*;

	// exact for every magnitude below 2**ACC_W
	localparam int DIV_LOG = $clog2(AVG_DIVISOR);
	localparam int SHIFT   = ACC_W + DIV_LOG;
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + 64'(AVG_DIVISOR) - 64'd1) / 64'(AVG_DIVISOR);
	localparam int RECIP_W = $clog2(RECIP + 64'd1);
	localparam int PROD_W  = ACC_W + RECIP_W;
	localparam int QW      = PROD_W - SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
	localparam logic [QW-1:0] POS_LIM = QW'(32767);
	localparam logic [QW-1:0] NEG_LIM = QW'(32768);

	logic                neg;
	logic [ACC_W-1:0]    mag;
	logic [PROD_W-1:0]   prod;

	logic [PROD_W-1:0]   prod_s4;
	logic                neg_s4;
	logic                kind_s4;
	logic [SAMPLE_W-1:0] value_s4;
	logic                ok_s4;

	logic [QW-1:0]       quo;
	logic [SAMPLE_W-1:0] avg;

	always_comb begin
		neg  = res.acc[ACC_W-1];
		mag  = neg ? (~res.acc + 1'b1) : res.acc;
		prod = PROD_W'(mag) * PROD_W'(RECIP_C);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4  <= prod;
			neg_s4   <= neg;
			kind_s4  <= res.kind;
			value_s4 <= res.value;
			ok_s4    <= res.ok;
		end
	end

	always_comb begin
		quo = prod_s4[PROD_W-1:SHIFT];
		if (!neg_s4 && (quo > POS_LIM)) begin
			avg = 16'h7FFF;
		end else if (neg_s4 && (quo > NEG_LIM)) begin
			avg = 16'h8000;
		end else if (neg_s4) begin
			avg = 16'(-quo[15:0]);
		end else begin
			avg = quo[15:0];
		end
		msg.kind  = kind_s4;
		msg.value = (kind_s4 == KIND_ERR) ? value_s4 : avg;
		msg.ok    = ok_s4;
	end

endmodule

>>> design/speed_sample_plausibility_filter.sv
// Top level of the speed sample plausibility filter.
// Uses sspf_pkg, sspf_scale, sspf_track and sspf_div.
//
//  port group  | dir | payload (low bit first)               | transaction
//  ------------+-----+---------------------------------------+---------------------------
//  s_t*        | in  | tdata: raw_sample[15:0]; tuser: func  | s_tvalid & s_tready
//  m_t*        | out | tdata: msg_value[15:0], ok_status,    | m_tvalid & m_tready
//              |     |   7 zero bits; tuser: msg_kind        |
//  cfg_*       | in  | cfg_index[2:0], cfg_data[15:0]        | cfg_valid & cfg_ready
//
// One item per cycle sustained while m_tready keeps up. Five register stages from input to m_t*:
// input (s1), scaled sample (s2), tracker result (s3), reciprocal product (s4),
// output register. The tracker state updates as an item leaves s2, so
// back-to-back items see each other's effect without bubbles. arst_n clears
// all valid bits, the tracker state and the configuration registers to their
// defaults; no clearing pass. A stalled output only blocks s_tready once
// every stage behind it is full.
module speed_sample_plausibility_filter #(
	parameter int AVG_DIVISOR = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] raw_sample
	input  logic [0:0]  s_tuser,   // [0] func
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] msg_value, [16] ok_status, [23:17] zero
	output logic [0:0]  m_tuser,   // [0] msg_kind
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sspf_pkg::*;

	sspf_cfg_t           cfg_q;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic                func_s1, func_s2;
	logic [SAMPLE_W-1:0] raw_s1;
	logic [SAMPLE_W-1:0] scaled_s2;
	sspf_res_t           res_s3;

	logic                out_valid_q;
	sspf_msg_t           out_q;

	logic                rdy_o, rdy4, rdy3, rdy2, rdy1;
	logic [SAMPLE_W-1:0] scaled;
	logic                has_res;
	sspf_res_t           res;
	sspf_msg_t           msg;

	// configuration: always ready; the user must write only while the pipe is idle, which the block does not check
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_normal        <= RST_MAX_NORMAL;
			cfg_q.invalid_run_limit <= RST_RUN_LIMIT;
			cfg_q.jump_gap          <= RST_GAP;
			cfg_q.window_ticks      <= RST_WINDOW;
			cfg_q.scale_q8          <= RST_SCALE;
		end else if (cfg_valid) begin
			case (sspf_cfg_idx_t'(cfg_index))
				CFG_MAX_NORMAL: cfg_q.max_normal        <= cfg_data;
				CFG_RUN_LIMIT:  cfg_q.invalid_run_limit <= cfg_data[7:0];
				CFG_GAP:        cfg_q.jump_gap          <= cfg_data;
				CFG_WINDOW:     cfg_q.window_ticks      <= cfg_data[7:0];
				CFG_SCALE:      cfg_q.scale_q8          <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage advance: a stage moves when it is empty or its successor moves
	always_comb begin
		rdy_o = !out_valid_q || m_tready;
		rdy4  = !v_s4 || rdy_o;
		rdy3  = !v_s3 || rdy4;
		rdy2  = !v_s2 || rdy3;
		rdy1  = !v_s1 || rdy2;
	end

	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			// items that cause no result end at the tracker
			if (rdy3) v_s3 <= v_s2 && has_res;
			if (rdy4) v_s4 <= v_s3;
			if (rdy_o) out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			func_s1 <= s_tuser[0];
			raw_s1  <= s_tdata;
		end
		if (rdy2 && v_s1) begin
			func_s2   <= func_s1;
			scaled_s2 <= scaled;
		end
		if (rdy3 && v_s2) begin
			res_s3 <= res;
		end
		if (rdy_o && v_s4) begin
			out_q <= msg;
		end
	end

	sspf_scale u_scale (
		.raw_sample (raw_s1),
		.scale_q8   (cfg_q.scale_q8),
		.scaled     (scaled)
	);

	sspf_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (v_s2 && rdy3),
		.func    (func_s2),
		.scaled  (scaled_s2),
		.cfg     (cfg_q),
		.has_res (has_res),
		.res     (res)
	);

	sspf_div #(
		.AVG_DIVISOR (AVG_DIVISOR)
	) u_div (
		.clk (clk),
		.en  (rdy4 && v_s3),
		.res (res_s3),
		.msg (msg)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.ok, out_q.value};
	assign m_tuser  = out_q.kind;

endmodule

>>> design/sspf_checker.sv
// Port-level checks for the speed sample plausibility filter, bound to the top.
// Uses sspf_pkg for the message kind codes.
module sspf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [0:0]  m_tuser
);
	import sspf_pkg::*;

	logic [31:0] in_cnt_q;
	logic [31:0] out_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (s_tvalid && s_tready) in_cnt_q <= in_cnt_q + 32'd1;
			if (m_tvalid && m_tready) out_cnt_q <= out_cnt_q + 32'd1;
		end
	end

	// a stalled result holds still
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// never more results than items taken in
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (in_cnt_q > out_cnt_q))
		else $error("result without a pending item");

	// an error report always carries a cleared ok status
	a_err_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == KIND_ERR) |-> !m_tdata[16])
		else $error("error report with ok status set");

	// input backpressure only comes from a waiting result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

endmodule

bind speed_sample_plausibility_filter sspf_checker u_sspf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> verif/speed_sample_plausibility_filter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for speed_sample_plausibility_filter.
// Needs sspf_pkg and the filter RTL. A directed table runs first, then random
// register settings; outputs are checked against typed-in messages or a behavioral filter model.
module speed_sample_plausibility_filter_tb;
	import sspf_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int AVG_DIV    = 20;
	localparam int RST_CYCLES = 6;
	// Settling time, in cycles, after the last owed message has arrived.
	localparam int SETTLE     = 10;
	// Long receiver hold-off, in cycles, to fill the pipe and stall s_tready.
	localparam int RX_HOLD    = 400;
	// Above the worst honest run (every item behind the longest sender gap,
	// every result behind the longest receiver stall, one long hold-off).
	localparam int TIMEOUT_CYCLES = 1000000;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	// One line of the directed table: a register write or an input item,
	// with the expected message typed in where it is obvious.
	typedef struct {
		row_kind_t     kind;
		sspf_cfg_idx_t idx;
		logic [15:0]   data;
		logic          func;
		bit            typed;
		bit            has_msg;
		sspf_msg_t     msg;
	} row_t;

	// One random register setting and the flavor of traffic run under it.
	typedef struct {
		logic [15:0] max_normal;
		logic [7:0]  run_limit;
		logic [15:0] gap;
		logic [7:0]  window;
		logic [15:0] scale;
		int          n_items;
		int          base;
	} setting_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	speed_sample_plausibility_filter #(
		.AVG_DIVISOR(AVG_DIV)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------
	// Filter model: register copies and state, updated per accepted
	// input transaction and per register write.
	// ---------------------------------------------------------------
	logic signed [15:0] r_max_normal = RST_MAX_NORMAL;
	logic [7:0]         r_run_limit  = RST_RUN_LIMIT;
	logic [15:0]        r_gap        = RST_GAP;
	logic [7:0]         r_window     = RST_WINDOW;
	logic [15:0]        r_scale      = RST_SCALE;

	logic [7:0]         tick_cnt = '0;
	logic [7:0]         over_run = '0;   // saturates at 255
	int                 speed_sum = 0;   // 25-bit signed window sum
	logic signed [15:0] held_speed = '0;
	bit                 held_ok = 1'b0;
	bit                 speed_ok = 1'b1;

	sspf_msg_t pending_msgs[$];   // messages owed by the filter, oldest first

	int  n_fail = 0;
	int  n_items = 0;
	int  n_writes = 0;
	int  n_settings = 0;
	int  n_err_msgs = 0;
	int  n_avg_msgs = 0;
	int  n_in_stalls = 0;
	bit  tx_calm = 1'b0;
	bit  hold_req = 1'b0;
	sspf_msg_t want_msg;

	function automatic logic signed [15:0] sat16(longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// Q8.8 gain, truncated toward zero, clipped to 16 bits
	function automatic logic signed [15:0] scale_speed(logic [15:0] raw);
		longint prod;
		prod = longint'($signed(raw)) * longint'(r_scale);
		return sat16(prod / 256);
	endfunction

	function automatic void add_to_sum(logic signed [15:0] v);
		longint s;
		s = longint'(speed_sum) + longint'(v);
		if (s > 16777215)
			s = 16777215;
		if (s < -16777216)
			s = -16777216;
		speed_sum = int'(s);
	endfunction

	// Advances the filter by one item; returns 1 and the message when one is due.
	function automatic bit filter_step(logic func, logic [15:0] raw, output sspf_msg_t m);
		logic signed [15:0] sc;
		int jump;
		m = '0;
		tick_cnt = tick_cnt + 8'd1;
		if (func == FUNC_SAMPLE) begin
			sc = scale_speed(raw);
			if (sc > r_max_normal) begin
				if (over_run != 8'hFF)
					over_run = over_run + 8'd1;
				// error clears the window, so it wins over a due report
				if (over_run > r_run_limit) begin
					speed_ok = 1'b0;
					tick_cnt = '0;
					speed_sum = 0;
					m.kind = KIND_ERR;
					m.value = sc;
					m.ok = 1'b0;
					return 1'b1;
				end
			end else begin
				over_run = '0;
				speed_ok = 1'b1;
				jump = int'(sc) - int'(held_speed);
				if (jump < 0)
					jump = -jump;
				if (!held_ok || jump < int'(r_gap)) begin
					add_to_sum(sc);
					held_speed = sc;
					held_ok = 1'b1;
				end else begin
					add_to_sum(held_speed);
				end
			end
		end
		if (tick_cnt == r_window) begin
			m.kind = KIND_AVG;
			m.value = sat16(longint'(speed_sum) / AVG_DIV);
			m.ok = speed_ok;
			tick_cnt = '0;
			speed_sum = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------
	// Directed table rows
	// ---------------------------------------------------------------
	function automatic row_t cfg_row(sspf_cfg_idx_t idx, logic [15:0] data);
		row_t r;
		r = '{kind: ROW_CFG, idx: idx, default: '0};
		r.data = data;
		return r;
	endfunction

	function automatic row_t item_row(logic func, logic [15:0] raw);
		row_t r;
		r = '{kind: ROW_ITEM, idx: CFG_MAX_NORMAL, default: '0};
		r.func = func;
		r.data = raw;
		return r;
	endfunction

	// item whose outcome is typed in: no message, or the given one
	function automatic row_t item_chk(logic func, logic [15:0] raw, bit has_msg,
			logic kind, logic [15:0] value, logic ok);
		row_t r;
		r = item_row(func, raw);
		r.typed = 1'b1;
		r.has_msg = has_msg;
		r.msg.kind = kind;
		r.msg.value = value;
		r.msg.ok = ok;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------
	// Gap before the next item: mostly none, some short, a few long.
	function automatic int tx_gap();
		int r;
		if (tx_calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offers one item, waits for its transaction, then books the outcome.
	task automatic send_item(logic func, logic [15:0] raw, bit typed = 1'b0,
			bit has_msg = 1'b0, sspf_msg_t typed_msg = '0);
		int gap;
		bit due;
		sspf_msg_t m;
		gap = tx_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= raw;
		do @(posedge clk); while (!s_tready);
		due = filter_step(func, raw, m);
		if (typed) begin
			due = has_msg;
			m = typed_msg;
		end
		if (due)
			pending_msgs.push_back(m);
		n_items++;
	endtask

	// Stop offering, let every owed message arrive, then let the pipe settle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_msgs.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register write; only called with the filter idle.
	task automatic write_reg(sspf_cfg_idx_t idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MAX_NORMAL: r_max_normal = data;
			CFG_RUN_LIMIT:  r_run_limit = data[7:0];
			CFG_GAP:        r_gap = data;
			CFG_WINDOW:     r_window = data[7:0];
			CFG_SCALE:      r_scale = data;
			default: ;
		endcase
		n_writes++;
		@(posedge clk);
	endtask

	// Raw value whose scaled speed falls above (or not above) max_normal,
	// drawn near the setting's base or anywhere; gives up after a few tries.
	function automatic logic [15:0] pick_raw(bit want_over, int base);
		logic [15:0] raw;
		raw = '0;
		for (int i = 0; i < 16; i++) begin
			if ($urandom_range(0, 1))
				raw = 16'($urandom_range(0, 65535));
			else
				raw = sat16(base + int'($urandom_range(0, 4000)) - 2000);
			if ((scale_speed(raw) > r_max_normal) == want_over)
				return raw;
		end
		return raw;
	endfunction

	// ---------------------------------------------------------------
	// Receiver side: random stalls, calm stretches, and one long
	// hold-off on request, all counted here in cycles.
	// ---------------------------------------------------------------
	initial begin
		int r;
		int open_left;
		open_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
				m_tready <= 1'b1;
			end else if (open_left > 0) begin
				open_left--;
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					open_left = $urandom_range(30, 80);
					m_tready <= 1'b1;
				end else if (r < 70) begin
					m_tready <= 1'b1;
				end else if (r < 95) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(0, 2)) @(posedge clk);
				end else begin
					m_tready <= 1'b0;
					repeat ($urandom_range(10, 40)) @(posedge clk);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Result check: every output transaction against the oldest
	// owed message, field by field.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && s_tvalid && !s_tready)
			n_in_stalls++;
		if (arst_n && m_tvalid && m_tready) begin
			if (m_tuser[0] == KIND_ERR)
				n_err_msgs++;
			else
				n_avg_msgs++;
			if (pending_msgs.size() == 0) begin
				$error("unexpected result: msg_kind %0d msg_value %0d ok_status %0d",
					m_tuser[0], $signed(m_tdata[15:0]), m_tdata[16]);
				n_fail++;
			end else begin
				want_msg = pending_msgs.pop_front();
				if (m_tuser[0] !== want_msg.kind) begin
					$error("msg_kind: expected %0d, got %0d", want_msg.kind, m_tuser[0]);
					n_fail++;
				end
				if (m_tdata[15:0] !== want_msg.value) begin
					$error("msg_value: expected %0d, got %0d",
						$signed(want_msg.value), $signed(m_tdata[15:0]));
					n_fail++;
				end
				if (m_tdata[16] !== want_msg.ok) begin
					$error("ok_status: expected %0d, got %0d", want_msg.ok, m_tdata[16]);
					n_fail++;
				end
				if (m_tdata[23:17] !== 7'd0) begin
					$error("tdata pad: expected 0, got %0h", m_tdata[23:17]);
					n_fail++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		row_t       rows[$];
		setting_t   plan[$];
		setting_t   ph;
		int         sent;
		int         burst;
		int         len;
		int         walk_v;
		bit         hold_done;
		bit         pause_done;
		logic [15:0] raw;
		logic       func;

		// After reset, defaults: a lone sample makes no report yet.
		rows.push_back(item_chk(FUNC_SAMPLE, 16'd0, 1'b0, KIND_AVG, 16'd0, 1'b0));
		// Two-tick window: the idle tick closes it with an all-zero average.
		rows.push_back(cfg_row(CFG_WINDOW, 16'd2));
		rows.push_back(item_chk(FUNC_TICK, 16'hFFFF, 1'b1, KIND_AVG, 16'd0, 1'b1));
		// Zero run limit: first over-limit sample errors, and again on the next.
		rows.push_back(cfg_row(CFG_MAX_NORMAL, 16'd100));
		rows.push_back(cfg_row(CFG_RUN_LIMIT, 16'd0));
		rows.push_back(cfg_row(CFG_WINDOW, 16'd3));
		rows.push_back(item_chk(FUNC_SAMPLE, 16'd101, 1'b1, KIND_ERR, 16'd101, 1'b0));
		rows.push_back(item_chk(FUNC_SAMPLE, 16'h7FFF, 1'b1, KIND_ERR, 16'h7FFF, 1'b0));
		// in-gap sample taken, far jump replaced by the held 50: sum 100, average 5
		rows.push_back(item_row(FUNC_SAMPLE, 16'd50));
		rows.push_back(item_row(FUNC_SAMPLE, 16'h8000));
		rows.push_back(item_chk(FUNC_TICK, 16'd0, 1'b1, KIND_AVG, 16'd5, 1'b1));
		// Full gain, widest gap, no limit: products saturate both ways.
		rows.push_back(cfg_row(CFG_SCALE, 16'hFFFF));
		rows.push_back(cfg_row(CFG_RUN_LIMIT, 16'd255));
		rows.push_back(cfg_row(CFG_MAX_NORMAL, 16'h7FFF));
		rows.push_back(cfg_row(CFG_GAP, 16'hFFFF));
		rows.push_back(item_row(FUNC_SAMPLE, 16'h7FFF));
		rows.push_back(item_row(FUNC_SAMPLE, 16'h8000));
		rows.push_back(item_row(FUNC_SAMPLE, 16'hFFFF));
		// Zero gain and zero gap: nothing new is ever taken, held value repeats.
		rows.push_back(cfg_row(CFG_SCALE, 16'd0));
		rows.push_back(cfg_row(CFG_GAP, 16'd0));
		rows.push_back(item_row(FUNC_SAMPLE, 16'd12345));
		rows.push_back(item_row(FUNC_SAMPLE, 16'h8000));
		rows.push_back(item_row(FUNC_TICK, 16'h5555));
		// Error landing on the window tick: the error wins, no report;
		// the following report still carries ok_status 0.
		rows.push_back(cfg_row(CFG_SCALE, 16'd256));
		rows.push_back(cfg_row(CFG_MAX_NORMAL, 16'd10));
		rows.push_back(cfg_row(CFG_RUN_LIMIT, 16'd1));
		rows.push_back(cfg_row(CFG_WINDOW, 16'd2));
		rows.push_back(cfg_row(CFG_GAP, 16'd100));
		rows.push_back(item_chk(FUNC_SAMPLE, 16'd20, 1'b0, KIND_AVG, 16'd0, 1'b0));
		rows.push_back(item_chk(FUNC_SAMPLE, 16'd30, 1'b1, KIND_ERR, 16'd30, 1'b0));
		rows.push_back(item_chk(FUNC_TICK, 16'd0, 1'b0, KIND_AVG, 16'd0, 1'b0));
		rows.push_back(item_chk(FUNC_TICK, 16'hAAAA, 1'b1, KIND_AVG, 16'd0, 1'b0));
		rows.push_back(item_row(FUNC_SAMPLE, 16'd5));

		// Random settings: max_normal, run limit, gap, window, gain, items, base
		plan.push_back('{16'h7FFF, 8'd3, 16'd100, 8'd20, 16'd256, 250, 0});
		plan.push_back('{16'd1000, 8'd2, 16'd500, 8'd10, 16'd256, 250, 800});
		// one report per item: the long receiver hold-off goes here
		plan.push_back('{16'd0, 8'd0, 16'd0, 8'd1, 16'd128, 200, -200});
		// 256-tick window of saturated positive speeds: average clips high
		plan.push_back('{16'h7FFF, 8'd255, 16'hFFFF, 8'd0, 16'hFFFF, 280, 30000});
		// nearly all over the limit, limit 255: run count pins at 255, no error
		plan.push_back('{16'h8000, 8'd255, 16'd50, 8'd255, 16'd256, 270, -30000});
		// average clips low; the sender pauses midway until all is delivered
		plan.push_back('{16'h7FFF, 8'd1, 16'd2000, 8'd0, 16'd512, 260, -30000});
		ph.max_normal = 16'($urandom_range(0, 65535));
		ph.run_limit = 8'($urandom_range(0, 8));
		ph.gap = 16'($urandom_range(0, 65535));
		ph.window = 8'($urandom_range(0, 255));
		ph.scale = 16'($urandom_range(0, 65535));
		ph.n_items = 140;
		ph.base = int'($urandom_range(0, 65535)) - 32768;
		plan.push_back(ph);

		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				wait_drained();
				write_reg(rows[i].idx, rows[i].data);
			end else begin
				send_item(rows[i].func, rows[i].data, rows[i].typed,
					rows[i].has_msg, rows[i].msg);
			end
		end

		// random part, one register setting at a time
		hold_done = 1'b0;
		pause_done = 1'b0;
		foreach (plan[p]) begin
			ph = plan[p];
			wait_drained();
			write_reg(CFG_MAX_NORMAL, ph.max_normal);
			write_reg(CFG_RUN_LIMIT, {8'd0, ph.run_limit});
			write_reg(CFG_GAP, ph.gap);
			write_reg(CFG_WINDOW, {8'd0, ph.window});
			write_reg(CFG_SCALE, ph.scale);
			n_settings++;
			sent = 0;
			while (sent < ph.n_items) begin
				tx_calm = ($urandom_range(0, 9) == 0);
				if (ph.window == 8'd1 && !hold_done && sent >= 30) begin
					// receiver holds off while items keep coming
					hold_req = 1'b1;
					hold_done = 1'b1;
					tx_calm = 1'b1;
				end
				if (p == 5 && !pause_done && sent >= ph.n_items / 2) begin
					wait_drained();
					pause_done = 1'b1;
				end
				burst = $urandom_range(0, 99);
				if (burst < 45) begin
					// plausible drive: small steps, some jumps, some idle ticks
					len = $urandom_range(1, 12);
					walk_v = ph.base + int'($urandom_range(0, 400)) - 200;
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(0, 6) == 0)
							walk_v += int'($urandom_range(0, 4000)) - 2000;
						else
							walk_v += int'($urandom_range(0, 60)) - 30;
						raw = sat16(walk_v);
						walk_v = int'($signed(raw));
						func = ($urandom_range(0, 4) == 0) ? FUNC_TICK : FUNC_SAMPLE;
						send_item(func, raw);
					end
				end else if (burst < 70) begin
					// over-limit run around the limit length, now and then very long
					if (r_run_limit < 8'd12)
						len = $urandom_range(1, int'(r_run_limit) + 3);
					else if ($urandom_range(0, 3) == 0)
						len = $urandom_range(256, 270);
					else
						len = $urandom_range(1, 12);
					for (int k = 0; k < len; k++)
						send_item(FUNC_SAMPLE, pick_raw(1'b1, ph.base));
					// usually broken off by an in-range sample
					if ($urandom_range(0, 2) != 0) begin
						send_item(FUNC_SAMPLE, pick_raw(1'b0, ph.base));
						len++;
					end
				end else if (burst < 85) begin
					len = $urandom_range(1, 5);
					for (int k = 0; k < len; k++)
						send_item(FUNC_TICK, 16'($urandom_range(0, 65535)));
				end else begin
					len = 1;
					case ($urandom_range(0, 5))
						0: raw = 16'h7FFF;
						1: raw = 16'h8000;
						2: raw = 16'hFFFF;
						3: raw = 16'h0001;
						default: raw = 16'($urandom_range(0, 65535));
					endcase
					func = $urandom_range(0, 1) ? FUNC_TICK : FUNC_SAMPLE;
					send_item(func, raw);
				end
				sent += len;
			end
		end

		tx_calm = 1'b0;
		wait_drained();
		$display("Covered %0d items: directed table plus %0d random settings, %0d reg writes.",
			n_items, n_settings, n_writes);
		$display("Checked %0d high-speed errors, %0d window averages; input stalled %0d cycles.",
			n_err_msgs, n_avg_msgs, n_in_stalls);
		if (n_fail == 0) begin
			$display("speed_sample_plausibility_filter_tb passed");
		end else begin
			$display("speed_sample_plausibility_filter_tb failed");
		end
		$finish;
	end

	// Hard stop if a handshake never completes.
	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("speed_sample_plausibility_filter_tb failed");
		$finish;
	end

endmodule
